>>> rtl/core/rfd_pkg.sv
// ----------------------------------------------------------------------------
// rfd_pkg
// Shared types and constants for the rectangle fill display streamer.
// ----------------------------------------------------------------------------
package rfd_pkg;

	// Screen size in pixels.
	localparam int SCREEN_WIDTH  = 128;
	localparam int SCREEN_HEIGHT = 128;

	// Field widths of the stream beats.
	localparam int COORD_IN_W = 9;
	localparam int SIZE_W     = 9;
	localparam int COLOR_W    = 16;
	localparam int BYTE_W     = 8;
	localparam int S_TDATA_W  = 56;
	localparam int M_TDATA_W  = 8;

	// Internal widths: clipped coordinates, spans and pixel counts.
	localparam int COORD_W = 8;
	localparam int SPAN_W  = 9;
	localparam int WIDE_W  = 11;
	localparam int PIX_W   = 17;
	localparam int STEP_W  = 4;

	// Controller command bytes.
	localparam logic [BYTE_W-1:0] CMD_COLUMN_SET   = 8'h2A;
	localparam logic [BYTE_W-1:0] CMD_ROW_SET      = 8'h2B;
	localparam logic [BYTE_W-1:0] CMD_MEMORY_WRITE = 8'h2C;

	// Header byte positions; the pixel phase follows the header.
	localparam logic [STEP_W-1:0] STEP_COL_CMD   = 4'd0;
	localparam logic [STEP_W-1:0] STEP_COL_START = 4'd2;
	localparam logic [STEP_W-1:0] STEP_COL_END   = 4'd4;
	localparam logic [STEP_W-1:0] STEP_ROW_CMD   = 4'd5;
	localparam logic [STEP_W-1:0] STEP_ROW_START = 4'd7;
	localparam logic [STEP_W-1:0] STEP_ROW_END   = 4'd9;
	localparam logic [STEP_W-1:0] STEP_MEM_WRITE = 4'd10;
	localparam logic [STEP_W-1:0] PIXEL_PHASE    = 4'd11;

	// Queue between the front and the back.
	localparam int Q_DEPTH = 4;
	localparam int Q_AW    = 2;
	localparam int Q_CW    = 3;

	// Kind of an incoming beat.
	typedef enum logic {
		KIND_RECT = 1'b0,
		KIND_TICK = 1'b1
	} kind_t;

	// Operation carried through the queue.
	typedef enum logic {
		OP_LOAD = 1'b0,
		OP_EMIT = 1'b1
	} op_t;

	// One incoming command.
	typedef struct packed {
		kind_t                        kind;
		logic signed [COORD_IN_W-1:0] rect_x;
		logic signed [COORD_IN_W-1:0] rect_y;
		logic [SIZE_W-1:0]            rect_width;
		logic [SIZE_W-1:0]            rect_height;
		logic [COLOR_W-1:0]           fill_color;
	} rect_cmd_t;

	// One queue entry: a window load or a byte request.
	typedef struct packed {
		op_t                op;
		logic               last;
		logic [COORD_W-1:0] col_start;
		logic [COORD_W-1:0] col_end;
		logic [COORD_W-1:0] row_start;
		logic [COORD_W-1:0] row_end;
		logic [COLOR_W-1:0] color;
	} q_entry_t;

	// Push side of the queue.
	typedef struct packed {
		logic     push;
		q_entry_t entry;
	} q_push_t;

	// Pop side of the queue.
	typedef struct packed {
		logic     valid;
		q_entry_t entry;
	} q_head_t;

endpackage

>>> rtl/core/rfd_front.sv
// ----------------------------------------------------------------------------
// rfd_front
// Accepts rectangles and ticks, clips rectangles to the screen, tracks the
// stream length and queues window loads and byte requests for the back.
// ----------------------------------------------------------------------------
module rfd_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  rfd_pkg::rect_cmd_t cmd,
	input  logic              q_full,
	output rfd_pkg::q_push_t  q_push
);

	localparam logic signed [rfd_pkg::WIDE_W-1:0] SW_S = rfd_pkg::WIDE_W'(rfd_pkg::SCREEN_WIDTH);
	localparam logic signed [rfd_pkg::WIDE_W-1:0] SH_S =
		rfd_pkg::WIDE_W'(rfd_pkg::SCREEN_HEIGHT);

	logic                                busy_q;
	logic [rfd_pkg::STEP_W-1:0]          hdr_q;
	logic                                half_q;
	logic [rfd_pkg::PIX_W-1:0]           pix_cnt_q;
	logic [rfd_pkg::PIX_W-1:0]           total_q;
	logic [rfd_pkg::SPAN_W-1:0]          span_w_q;
	logic [rfd_pkg::SPAN_W-1:0]          span_h_q;

	logic                                accept;
	logic                                take_rect;
	logic                                take_tick;
	logic                                rect_ok;
	logic                                last_beat;
	logic signed [rfd_pkg::WIDE_W-1:0]   x0_e, y0_e, x1_e, y1_e;
	logic signed [rfd_pkg::WIDE_W-1:0]   x0_c, y0_c, x1_c, y1_c;
	logic [rfd_pkg::WIDE_W-1:0]          span_w, span_h;
	logic [2*rfd_pkg::SPAN_W-1:0]        area;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;

	// Corners in a wider signed range, then the clip against the screen.
	always_comb begin
		x0_e = {{(rfd_pkg::WIDE_W-rfd_pkg::COORD_IN_W){cmd.rect_x[rfd_pkg::COORD_IN_W-1]}},
			cmd.rect_x};
		y0_e = {{(rfd_pkg::WIDE_W-rfd_pkg::COORD_IN_W){cmd.rect_y[rfd_pkg::COORD_IN_W-1]}},
			cmd.rect_y};
		x1_e = x0_e + $signed({2'b00, cmd.rect_width}) - 11'sd1;
		y1_e = y0_e + $signed({2'b00, cmd.rect_height}) - 11'sd1;
		rect_ok = (cmd.rect_width != '0) && (cmd.rect_height != '0) &&
			!x1_e[rfd_pkg::WIDE_W-1] && !y1_e[rfd_pkg::WIDE_W-1] &&
			!(x0_e >= SW_S) && !(y0_e >= SH_S);
		x0_c = x0_e[rfd_pkg::WIDE_W-1] ? '0 : x0_e;
		y0_c = y0_e[rfd_pkg::WIDE_W-1] ? '0 : y0_e;
		x1_c = (x1_e >= SW_S) ? SW_S - 11'sd1 : x1_e;
		y1_c = (y1_e >= SH_S) ? SH_S - 11'sd1 : y1_e;
		span_w = $unsigned(x1_c - x0_c + 11'sd1);
		span_h = $unsigned(y1_c - y0_c + 11'sd1);
	end

	assign take_rect = accept && (cmd.kind == rfd_pkg::KIND_RECT) && !busy_q && rect_ok;
	assign take_tick = accept && (cmd.kind == rfd_pkg::KIND_TICK) && busy_q;

	// The final beat is the low color byte of the last pixel.
	assign last_beat = (hdr_q == rfd_pkg::PIXEL_PHASE) && half_q &&
		(pix_cnt_q + 1'b1 == total_q);

	// Queue entry for a window load or a byte request.
	always_comb begin
		q_push.push            = take_rect || take_tick;
		q_push.entry.op        = take_rect ? rfd_pkg::OP_LOAD : rfd_pkg::OP_EMIT;
		q_push.entry.last      = take_tick && last_beat;
		q_push.entry.col_start = x0_c[rfd_pkg::COORD_W-1:0];
		q_push.entry.col_end   = x1_c[rfd_pkg::COORD_W-1:0];
		q_push.entry.row_start = y0_c[rfd_pkg::COORD_W-1:0];
		q_push.entry.row_end   = y1_c[rfd_pkg::COORD_W-1:0];
		q_push.entry.color     = cmd.fill_color;
	end

	// Pixel count of the window; ready long before the header is through.
	assign area = span_w_q * span_h_q;

	always_ff @(posedge clk) begin
		total_q <= area[rfd_pkg::PIX_W-1:0];
		if (take_rect) begin
			span_w_q <= span_w[rfd_pkg::SPAN_W-1:0];
			span_h_q <= span_h[rfd_pkg::SPAN_W-1:0];
		end
	end

	// Stream position as the back will see it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			hdr_q     <= '0;
			half_q    <= 1'b0;
			pix_cnt_q <= '0;
		end else if (take_rect) begin
			busy_q    <= 1'b1;
			hdr_q     <= '0;
			half_q    <= 1'b0;
			pix_cnt_q <= '0;
		end else if (take_tick) begin
			if (hdr_q != rfd_pkg::PIXEL_PHASE) begin
				hdr_q <= hdr_q + 1'b1;
			end else if (!half_q) begin
				half_q <= 1'b1;
			end else begin
				half_q    <= 1'b0;
				pix_cnt_q <= pix_cnt_q + 1'b1;
				if (last_beat) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

endmodule

>>> rtl/core/rfd_queue.sv
// ----------------------------------------------------------------------------
// rfd_queue
// Small register queue between the front and the back.
// ----------------------------------------------------------------------------
module rfd_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  rfd_pkg::q_push_t wr,
	output logic             full,
	input  logic             pop,
	output rfd_pkg::q_head_t head
);

	rfd_pkg::q_entry_t         slot_q [rfd_pkg::Q_DEPTH];
	logic [rfd_pkg::Q_AW-1:0]  wr_ptr_q;
	logic [rfd_pkg::Q_AW-1:0]  rd_ptr_q;
	logic [rfd_pkg::Q_CW-1:0]  count_q;
	logic                      do_push;
	logic                      do_pop;

	assign full       = (count_q == rfd_pkg::Q_CW'(rfd_pkg::Q_DEPTH));
	assign head.valid = (count_q != '0);
	assign head.entry = slot_q[rd_ptr_q];
	assign do_push    = wr.push && !full;
	assign do_pop     = pop && head.valid;

	// Entry storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= wr.entry;
		end
	end

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

>>> rtl/core/rfd_back.sv
// ----------------------------------------------------------------------------
// rfd_back
// Holds the current window and color and turns each byte request into the
// next header or pixel byte, held in an output register.
// ----------------------------------------------------------------------------
module rfd_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  rfd_pkg::q_head_t              head,
	output logic                          pop,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [rfd_pkg::BYTE_W-1:0]    out_byte,
	output logic                          out_is_data,
	output logic                          out_last
);

	logic [rfd_pkg::COORD_W-1:0] col_start_q, col_end_q, row_start_q, row_end_q;
	logic [rfd_pkg::COLOR_W-1:0] color_q;
	logic [rfd_pkg::STEP_W-1:0]  hdr_q;
	logic                        half_q;
	logic                        valid_q;
	logic [rfd_pkg::BYTE_W-1:0]  byte_q;
	logic                        is_data_q;
	logic                        last_q;

	logic                        emit;
	logic                        load;
	logic [rfd_pkg::BYTE_W-1:0]  next_byte;
	logic                        next_is_data;

	assign out_valid   = valid_q;
	assign out_byte    = byte_q;
	assign out_is_data = is_data_q;
	assign out_last    = last_q;

	assign pop  = head.valid && (!valid_q || out_ready);
	assign load = pop && (head.entry.op == rfd_pkg::OP_LOAD);
	assign emit = pop && (head.entry.op == rfd_pkg::OP_EMIT);

	// Byte for the current stream position.
	always_comb begin
		next_byte    = '0;
		next_is_data = 1'b1;
		if (hdr_q != rfd_pkg::PIXEL_PHASE) begin
			case (hdr_q)
				rfd_pkg::STEP_COL_CMD: begin
					next_byte    = rfd_pkg::CMD_COLUMN_SET;
					next_is_data = 1'b0;
				end
				rfd_pkg::STEP_COL_START: next_byte = col_start_q;
				rfd_pkg::STEP_COL_END:   next_byte = col_end_q;
				rfd_pkg::STEP_ROW_CMD: begin
					next_byte    = rfd_pkg::CMD_ROW_SET;
					next_is_data = 1'b0;
				end
				rfd_pkg::STEP_ROW_START: next_byte = row_start_q;
				rfd_pkg::STEP_ROW_END:   next_byte = row_end_q;
				rfd_pkg::STEP_MEM_WRITE: begin
					next_byte    = rfd_pkg::CMD_MEMORY_WRITE;
					next_is_data = 1'b0;
				end
				default: next_byte = '0;
			endcase
		end else if (!half_q) begin
			next_byte = color_q[rfd_pkg::COLOR_W-1:rfd_pkg::BYTE_W];
		end else begin
			next_byte = color_q[rfd_pkg::BYTE_W-1:0];
		end
	end

	// Window and color of the stream being sent.
	always_ff @(posedge clk) begin
		if (load) begin
			col_start_q <= head.entry.col_start;
			col_end_q   <= head.entry.col_end;
			row_start_q <= head.entry.row_start;
			row_end_q   <= head.entry.row_end;
			color_q     <= head.entry.color;
		end
	end

	// Position within the stream.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_q  <= '0;
			half_q <= 1'b0;
		end else if (load) begin
			hdr_q  <= '0;
			half_q <= 1'b0;
		end else if (emit) begin
			if (hdr_q != rfd_pkg::PIXEL_PHASE) begin
				hdr_q <= hdr_q + 1'b1;
			end else begin
				half_q <= !half_q;
			end
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (emit) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			byte_q    <= next_byte;
			is_data_q <= next_is_data;
			last_q    <= head.entry.last;
		end
	end

endmodule

>>> rtl/core/rect_fill_display_stream.sv
// An accepted tick is first written into the queue, then turned into its byte in
// the output register once that register is free or being emptied.
// Throughput: one beat per cycle on each side; the four-entry queue between
// the clipping front and the byte-generating back lets either side stall.
// Reset: asynchronous, active low; the block comes up idle with the queue and
// the output register empty.
// ----------------------------------------------------------------------------
// rect_fill_display_stream
// Clips rectangle commands to the screen and streams the address-window
// header and fill pixels to a display link, one byte per tick.
// ----------------------------------------------------------------------------
module rect_fill_display_stream (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// rect_x[8:0], rect_y[17:9], rect_width[26:18], rect_height[35:27],
	// fill_color[51:36], zero fill[55:52]
	input  logic [rfd_pkg::S_TDATA_W-1:0]   s_tdata,
	// kind[0]
	input  logic                            s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// link_byte[7:0]
	output logic [rfd_pkg::M_TDATA_W-1:0]   m_tdata,
	// is_data[0]
	output logic                            m_tuser,
	output logic                            m_tlast
);

	rfd_pkg::rect_cmd_t cmd;
	rfd_pkg::q_push_t   q_push;
	rfd_pkg::q_head_t   q_head;
	logic               q_full;
	logic               q_pop;

	// Unpack the slave beat.
	always_comb begin
		cmd.kind        = rfd_pkg::kind_t'(s_tuser);
		cmd.rect_x      = $signed(s_tdata[8:0]);
		cmd.rect_y      = $signed(s_tdata[17:9]);
		cmd.rect_width  = s_tdata[26:18];
		cmd.rect_height = s_tdata[35:27];
		cmd.fill_color  = s_tdata[51:36];
	end

	rfd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.cmd      (cmd),
		.q_full   (q_full),
		.q_push   (q_push)
	);

	rfd_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (q_push),
		.full   (q_full),
		.pop    (q_pop),
		.head   (q_head)
	);

	rfd_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (q_head),
		.pop         (q_pop),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.out_byte    (m_tdata),
		.out_is_data (m_tuser),
		.out_last    (m_tlast)
	);

endmodule

>>> rtl/core/rfd_checker.sv
// ----------------------------------------------------------------------------
// rfd_checker
// Port-level checks of the rectangle fill display streamer.
// ----------------------------------------------------------------------------
module rfd_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [rfd_pkg::M_TDATA_W-1:0] m_tdata,
	input logic                          m_tuser,
	input logic                          m_tlast
);

	// A stalled master beat holds its contents.
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser) &&
			$stable(m_tlast))
		else $error("master beat changed while stalled");

	// Command bytes are only the three window and write commands.
	a_cmd_byte: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> (m_tdata == rfd_pkg::CMD_COLUMN_SET) ||
			(m_tdata == rfd_pkg::CMD_ROW_SET) || (m_tdata == rfd_pkg::CMD_MEMORY_WRITE))
		else $error("command beat with unknown command byte");

	// The stream always ends on a pixel byte.
	a_last_is_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> m_tuser)
		else $error("last beat is a command byte");

	// The memory-write command is never the final beat, and a beat right after
	// a last beat was taken can only start a new header.
	a_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && m_tlast ##1 m_tvalid |-> !m_tuser &&
			(m_tdata == rfd_pkg::CMD_COLUMN_SET))
		else $error("stream after last beat does not open with a column command");

endmodule

bind rect_fill_display_stream rfd_checker u_rfd_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);

>>> tb/rect_fill_link_checker.sv
// ----------------------------------------------------------------------------
// rect_fill_link_checker
// Watches both stream channels of the rectangle fill streamer. It keeps its
// own copy of the clipping window and pixel counter, works out the link byte
// that every accepted tick should produce, and compares each byte beat on the
// master side with the oldest byte still due.
// ----------------------------------------------------------------------------
module rect_fill_link_checker
	import rfd_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	input  logic                 s_tready,
	// rect_x[8:0], rect_y[17:9], rect_width[26:18], rect_height[35:27],
	// fill_color[51:36], zero fill[55:52]
	input  logic [S_TDATA_W-1:0] s_tdata,
	// kind[0]
	input  logic                 s_tuser,
	input  logic                 m_tvalid,
	input  logic                 m_tready,
	// link_byte[7:0]
	input  logic [M_TDATA_W-1:0] m_tdata,
	// is_data[0]
	input  logic                 m_tuser,
	input  logic                 m_tlast,
	output int                   mismatch_count,
	output int                   pending_bytes,
	output logic                 stream_busy,
	output int                   effective_items
);
	timeunit 1ns;
	timeprecision 1ps;

	// Field positions inside the slave tdata.
	localparam int X_LSB = 0;
	localparam int Y_LSB = X_LSB + COORD_IN_W;
	localparam int W_LSB = Y_LSB + COORD_IN_W;
	localparam int H_LSB = W_LSB + SIZE_W;
	localparam int C_LSB = H_LSB + SIZE_W;

	// Data/command flag values on the link.
	localparam logic DC_COMMAND = 1'b0;
	localparam logic DC_DATA    = 1'b1;

	typedef struct packed {
		logic [BYTE_W-1:0] link_byte;
		logic              is_data;
		logic              last;
	} link_beat_t;

	// Predicted streamer state.
	logic               busy;
	logic [STEP_W-1:0]  header_step;
	logic [COORD_W-1:0] col_first;
	logic [COORD_W-1:0] col_last;
	logic [COORD_W-1:0] row_first;
	logic [COORD_W-1:0] row_last;
	logic [COLOR_W-1:0] held_color;
	int                 pixels_left;
	logic               low_half_next;

	link_beat_t link_bytes_due[$];
	int         beat_index;
	int         fail_count;
	int         effective_count;

	task automatic report_mismatch(input string what);
		$display("%0t: link beat %0d: %s", $time, beat_index, what);
		fail_count++;
	endtask

	// Clip a rectangle to the screen and open a stream, unless nothing is left.
	task automatic load_window(input logic [S_TDATA_W-1:0] data);
		int x0;
		int y0;
		int x1;
		int y1;
		int w;
		int h;
		x0 = $signed(data[X_LSB +: COORD_IN_W]);
		y0 = $signed(data[Y_LSB +: COORD_IN_W]);
		w  = data[W_LSB +: SIZE_W];
		h  = data[H_LSB +: SIZE_W];
		if (w == 0 || h == 0)
			return;
		x1 = x0 + w - 1;
		y1 = y0 + h - 1;
		if (x1 < 0 || y1 < 0 || x0 >= SCREEN_WIDTH || y0 >= SCREEN_HEIGHT)
			return;
		if (x0 < 0)
			x0 = 0;
		if (y0 < 0)
			y0 = 0;
		if (x1 >= SCREEN_WIDTH)
			x1 = SCREEN_WIDTH - 1;
		if (y1 >= SCREEN_HEIGHT)
			y1 = SCREEN_HEIGHT - 1;
		col_first     = COORD_W'(x0);
		col_last      = COORD_W'(x1);
		row_first     = COORD_W'(y0);
		row_last      = COORD_W'(y1);
		held_color    = data[C_LSB +: COLOR_W];
		pixels_left   = (x1 - x0 + 1) * (y1 - y0 + 1);
		low_half_next = 1'b0;
		header_step   = STEP_COL_CMD;
		busy          = 1'b1;
		effective_count++;
	endtask

	// Advance the prediction by one accepted slave beat.
	task automatic advance_stream(input kind_t kind, input logic [S_TDATA_W-1:0] data);
		link_beat_t beat;
		if (kind == KIND_RECT) begin
			// A rectangle during a stream is dropped on the floor.
			if (!busy)
				load_window(data);
			return;
		end
		if (!busy)
			return;
		beat.link_byte = '0;
		beat.is_data   = DC_DATA;
		beat.last      = 1'b0;
		if (header_step < PIXEL_PHASE) begin
			// Address window header; the unnamed steps are the zero high bytes.
			case (header_step)
				STEP_COL_CMD: begin
					beat.link_byte = CMD_COLUMN_SET;
					beat.is_data   = DC_COMMAND;
				end
				STEP_COL_START: beat.link_byte = col_first;
				STEP_COL_END:   beat.link_byte = col_last;
				STEP_ROW_CMD: begin
					beat.link_byte = CMD_ROW_SET;
					beat.is_data   = DC_COMMAND;
				end
				STEP_ROW_START: beat.link_byte = row_first;
				STEP_ROW_END:   beat.link_byte = row_last;
				STEP_MEM_WRITE: begin
					beat.link_byte = CMD_MEMORY_WRITE;
					beat.is_data   = DC_COMMAND;
				end
				default: beat.link_byte = '0;
			endcase
			header_step++;
		end else if (!low_half_next) begin
			beat.link_byte = held_color[15:8];
			low_half_next  = 1'b1;
		end else begin
			beat.link_byte = held_color[7:0];
			low_half_next  = 1'b0;
			if (pixels_left > 0)
				pixels_left--;
			if (pixels_left == 0) begin
				beat.last   = 1'b1;
				busy        = 1'b0;
				header_step = STEP_COL_CMD;
			end
		end
		link_bytes_due.push_back(beat);
		effective_count++;
	endtask

	// Compare one master beat with the oldest byte due.
	task automatic check_link_beat();
		link_beat_t want;
		if (link_bytes_due.size() == 0) begin
			report_mismatch($sformatf("byte %02h arrived with nothing due", m_tdata));
		end else begin
			want = link_bytes_due.pop_front();
			if (m_tdata != want.link_byte)
				report_mismatch($sformatf("link_byte %02h, expected %02h",
					m_tdata, want.link_byte));
			if (m_tuser != want.is_data)
				report_mismatch($sformatf("is_data %0b, expected %0b", m_tuser, want.is_data));
			if (m_tlast != want.last)
				report_mismatch($sformatf("last %0b, expected %0b", m_tlast, want.last));
		end
		beat_index++;
	endtask

	// The master side is handled first: a tick taken at this edge cannot
	// produce its byte at the same edge.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy            = 1'b0;
			header_step     = STEP_COL_CMD;
			col_first       = '0;
			col_last        = '0;
			row_first       = '0;
			row_last        = '0;
			held_color      = '0;
			pixels_left     = 0;
			low_half_next   = 1'b0;
			beat_index      = 0;
			fail_count      = 0;
			effective_count = 0;
			link_bytes_due.delete();
			mismatch_count  <= 0;
			pending_bytes   <= 0;
			stream_busy     <= 1'b0;
			effective_items <= 0;
		end else begin
			if (m_tvalid && m_tready)
				check_link_beat();
			if (s_tvalid && s_tready)
				advance_stream(kind_t'(s_tuser), s_tdata);
			mismatch_count  <= fail_count;
			pending_bytes   <= link_bytes_due.size();
			stream_busy     <= busy;
			effective_items <= effective_count;
		end
	end

endmodule

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives rectangle commands and byte ticks into the rectangle fill streamer
// with random gaps on the slave side and random stalls on the master side.
// A directed part covers dropped, clipped and corner rectangles; the random
// part mostly sends a rectangle and ticks until its stream ends.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import rfd_pkg::*;

	localparam int CLK_HALF     = 4;
	localparam int RESET_CYCLES = 9;
	localparam int RANDOM_ITEMS = 500;
	localparam int SETTLE       = 16;
	localparam int TIMEOUT_NS   = 40_000_000;

	logic                 clk      = 1'b0;
	logic                 arst_n   = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	// rect_x[8:0], rect_y[17:9], rect_width[26:18], rect_height[35:27],
	// fill_color[51:36], zero fill[55:52]
	logic [S_TDATA_W-1:0] s_tdata  = '0;
	// kind[0]
	logic                 s_tuser  = 1'b0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	// link_byte[7:0]
	logic [M_TDATA_W-1:0] m_tdata;
	// is_data[0]
	logic                 m_tuser;
	logic                 m_tlast;

	int   mismatch_count;
	int   pending_bytes;
	logic stream_busy;
	int   effective_items;

	logic calm       = 1'b0;
	int   calm_left  = 0;
	int   ready_hold = 0;

	rect_fill_display_stream DUT (.*);

	rect_fill_link_checker link_checker (.*);

	initial begin
		forever #(CLK_HALF) clk = ~clk;
	end

	initial begin
		#(TIMEOUT_NS);
		$display("rect_fill_display_stream test failed");
		$finish;
	end

	// Alternate between calm stretches with no idling and busy ones.
	always @(posedge clk) begin
		if (calm_left == 0) begin
			calm      <= ($urandom_range(0, 99) < 25);
			calm_left <= $urandom_range(50, 400);
		end else begin
			calm_left <= calm_left - 1;
		end
	end

	// Mostly short gaps, a few long ones, none while calm.
	function automatic int pick_gap();
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(4, 16);
	endfunction

	// Random stalls on the link side.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready   <= 1'b0;
			ready_hold <= 0;
		end else if (ready_hold != 0) begin
			m_tready   <= 1'b0;
			ready_hold <= ready_hold - 1;
		end else begin
			m_tready <= 1'b1;
			if (!calm && $urandom_range(0, 99) < 25)
				ready_hold <= pick_gap();
		end
	end

	function automatic logic [S_TDATA_W-1:0] pack_rect(input int x, input int y,
			input int w, input int h, input logic [COLOR_W-1:0] c);
		return {c, SIZE_W'(h), SIZE_W'(w), COORD_IN_W'(y), COORD_IN_W'(x)};
	endfunction

	// Present one beat and hold it until taken, then maybe leave a gap.
	task automatic send_beat(input kind_t k, input logic [S_TDATA_W-1:0] data);
		int gap;
		s_tvalid <= 1'b1;
		s_tuser  <= k;
		s_tdata  <= data;
		do @(posedge clk); while (!s_tready);
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_rect(input int x, input int y, input int w, input int h,
			input logic [COLOR_W-1:0] c);
		send_beat(KIND_RECT, pack_rect(x, y, w, h, c));
	endtask

	// Ticks carry random garbage in the rectangle fields.
	task automatic send_tick();
		send_beat(KIND_TICK, pack_rect(int'($urandom_range(0, 511)) - 256,
			int'($urandom_range(0, 511)) - 256, $urandom_range(0, 256),
			$urandom_range(0, 256), $urandom_range(0, 65535)));
	endtask

	// A random beat of either kind; a rectangle here is kept small.
	task automatic send_noise();
		send_beat(kind_t'($urandom_range(0, 1)), pack_rect(int'($urandom_range(0, 511)) - 256,
			int'($urandom_range(0, 511)) - 256, $urandom_range(0, 6),
			$urandom_range(0, 6), $urandom_range(0, 65535)));
	endtask

	// Tick until the predicted stream is over; the busy flag trails by one
	// beat, so one tick usually lands on an idle block.
	task automatic drain_stream(input int noise_pct);
		do begin
			if ($urandom_range(0, 99) < noise_pct)
				send_noise();
			else
				send_tick();
		end while (stream_busy);
	endtask

	// Hold off the sender until every byte due has come out.
	task automatic wait_for_results();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending_bytes != 0);
	endtask

	// One axis of a rectangle that leaves only a few visible pixels.
	task automatic pick_span(output int first, output int span);
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) begin
			span  = $urandom_range(1, 3);
			first = $urandom_range(0, 127);
		end else if (r < 75) begin
			span  = $urandom_range(1, 8);
			first = int'($urandom_range(0, 135)) - 8;
		end else if (r < 88) begin
			// Wide span hanging off the far edge.
			span  = $urandom_range(129, 256);
			first = 128 - int'($urandom_range(1, 3));
		end else begin
			// Wide span hanging off the near edge.
			span  = $urandom_range(129, 256);
			first = int'($urandom_range(1, 3)) - span;
		end
	endtask

	// A rectangle that leaves nothing to draw, then ticks into an idle block.
	task automatic send_dropped();
		int x;
		int y;
		int w;
		int h;
		x = int'($urandom_range(0, 511)) - 256;
		y = int'($urandom_range(0, 511)) - 256;
		w = $urandom_range(0, 256);
		h = $urandom_range(0, 256);
		case ($urandom_range(0, 5))
			0: w = 0;
			1: h = 0;
			2: x = $urandom_range(SCREEN_WIDTH, 255);
			3: y = $urandom_range(SCREEN_HEIGHT, 255);
			4: begin
				w = $urandom_range(1, 256);
				x = -w - int'($urandom_range(0, 256 - w));
			end
			default: begin
				h = $urandom_range(1, 256);
				y = -h - int'($urandom_range(0, 256 - h));
			end
		endcase
		send_rect(x, y, w, h, $urandom_range(0, 65535));
		repeat ($urandom_range(1, 2)) send_tick();
	endtask

	initial begin
		int x;
		int y;
		int w;
		int h;
		int r;
		int base;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Tick while idle and rectangles that leave nothing to draw.
		send_tick();
		send_rect(10, 10, 0, 5, 16'h1234);
		send_rect(10, 10, 5, 0, 16'h1234);
		send_rect(SCREEN_WIDTH, 0, 1, 1, 16'h4321);
		send_rect(0, SCREEN_HEIGHT, 1, 1, 16'h4321);
		send_rect(-5, 0, 5, 1, 16'h00FF);
		send_rect(0, -256, 1, 256, 16'hFF00);
		send_rect(-256, -256, 256, 256, 16'h0F0F);
		send_rect(255, 255, 256, 256, 16'hFFFF);
		send_tick();

		// Single pixel at the top-left corner; a rectangle mid-stream is ignored.
		send_rect(0, 0, 1, 1, 16'h0000);
		send_tick();
		send_rect(20, 20, 4, 4, 16'hBEEF);
		drain_stream(0);

		// Single pixel at the bottom-right corner.
		send_rect(127, 127, 1, 1, 16'hFFFF);
		drain_stream(0);

		// Clipped on the left and at the bottom.
		send_rect(-3, 125, 5, 10, 16'h5AA5);
		drain_stream(0);

		// Wide spans clipped down to one pixel at the left edge.
		send_rect(-255, 127, 256, 256, 16'hC3C3);
		drain_stream(0);

		// Wide span clipped at the right edge, and clipped at the top.
		send_rect(124, -5, 256, 8, 16'hA55A);
		drain_stream(0);
		wait_for_results();

		// Random part: mostly complete streams with a little noise mixed in.
		base = effective_items;
		while (effective_items - base < RANDOM_ITEMS) begin
			r = $urandom_range(0, 99);
			if (r < 75) begin
				pick_span(x, w);
				pick_span(y, h);
				send_rect(x, y, w, h, $urandom_range(0, 65535));
				drain_stream(8);
			end else if (r < 90) begin
				send_dropped();
			end else if (r < 95) begin
				send_noise();
			end else begin
				wait_for_results();
			end
		end

		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending_bytes != 0);
		repeat (SETTLE) @(posedge clk);
		if (mismatch_count == 0)
			$display("rect_fill_display_stream test passed");
		else
			$display("rect_fill_display_stream test failed");
		$finish;
	end

endmodule

>>> files.f
rtl/core/rfd_pkg.sv
rtl/core/rfd_front.sv
rtl/core/rfd_queue.sv
rtl/core/rfd_back.sv
rtl/core/rect_fill_display_stream.sv
rtl/core/rfd_checker.sv
tb/rect_fill_link_checker.sv
tb/testbench.sv
